// File: hdl/wrm_pkg.sv
package wrm_pkg;
  localparam int CHANNELS_DEF = 16;
  localparam int BUCKETS_DEF  = 256;
  localparam logic [31:0] PEAK_WIN_RST = 32'd10000;
  localparam logic [47:0] RATE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] SCALE_K = 32'd65536000;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_ONE  = 2'd1;
  localparam logic [1:0] ACT_ALL  = 2'd2;
  localparam logic [1:0] ACT_PEAK = 2'd3;
endpackage

// File: hdl/windowed_event_rate_meter.sv
// An add writes its sample and returns to idle; a single-channel query walks at most
//   BUCKETS-1 samples, then, when the rate is defined, multiplies and divides to form it.
// All-channel and peak queries repeat the walk and division for each channel in turn.
// Throughput: one item at a time; in_stall is high from acceptance until the beat leaves.
// Reset (rst_n, synchronous, low): clears pointers and peak, then sweeps every address of
//   the time memory to zero, during which no item is accepted.
module windowed_event_rate_meter #(
  parameter int CHANNELS = wrm_pkg::CHANNELS_DEF,
  parameter int BUCKETS  = wrm_pkg::BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_channel,
  input  logic [63:0] in_count,
  input  logic [63:0] in_timestamp,
  input  logic [31:0] in_window_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_rate,
  output logic        out_rate_valid,
  output logic [47:0] out_peak
);
  import wrm_pkg::*;

  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW  = BW + CW;
  localparam int DEP = CHANNELS * BUCKETS;
  localparam int CCW = CW + 1;

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHAN  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_EVAL  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_ADD   = 4'd10;

  logic [3:0]  state_r, state_nxt;

  // sample memories: written once per add, read at one address; the reset sweep also writes the time memory
  logic [63:0] cnt_mem [DEP];
  logic [63:0] tim_mem [DEP];
  logic [63:0] rd_cnt_r, rd_tim_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [63:0] mem_wc, mem_wt;
  logic        cnt_we;

  logic [BW-1:0] wptr_r [CHANNELS];
  logic [BW-1:0] wptr_nxt [CHANNELS];

  logic [AW-1:0] clr_r, clr_nxt;
  logic [31:0] pwin_r;
  logic [47:0] peak_r, peak_nxt;

  // held input beat
  logic [1:0]  act_r, act_nxt;
  logic [3:0]  ch_in_r, ch_in_nxt;
  logic [63:0] cnt_r, cnt_nxt, now_r, now_nxt;
  logic [31:0] win_r, win_nxt;

  // walk state
  logic [CCW-1:0] ch_r, ch_nxt;
  logic [BW-1:0]  idx_r, idx_nxt;
  logic [BW:0]    step_r, step_nxt;
  logic [63:0] new_t_r, new_t_nxt, new_c_r, new_c_nxt, old_t_r, old_t_nxt, old_c_r, old_c_nxt;
  logic        full_r, full_nxt;

  // shared divider datapath
  logic [63:0] den_r, den_nxt, mag_r, mag_nxt;
  logic [63:0] rem_r, rem_nxt, lo_r, lo_nxt, q_r, q_nxt;
  logic [6:0]  bit_r, bit_nxt;
  logic [1:0]  mph_r, mph_nxt;
  logic [63:0] p0_r, p0_nxt, p1_r, p1_nxt;
  logic        sat_r, sat_nxt;
  logic        cv_r, cv_nxt;
  logic [47:0] crate_r, crate_nxt;
  logic [47:0] sum_r, sum_nxt;

  logic [47:0] o_rate_r, o_rate_nxt, o_peak_r, o_peak_nxt;
  logic        o_rv_r, o_rv_nxt, o_v_r, o_v_nxt;

  logic [CW-1:0] ch_idx;
  logic [48:0]   sum_ext;
  logic [64:0]   rem_sh;
  logic          q_set;
  logic [63:0]   lo_sum;
  logic          neg_t, neg_c;
  logic [63:0]   dt_w, dc_w;
  logic [31:0]   cur_win;

  assign ch_idx  = ch_r[CW-1:0];
  assign cur_win = (act_r == ACT_PEAK) ? pwin_r : win_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tim_mem[mem_wa] <= mem_wt;
    end
    if (cnt_we) begin
      cnt_mem[mem_wa] <= mem_wc;
    end
    rd_tim_r <= tim_mem[mem_ra];
    rd_cnt_r <= cnt_mem[mem_ra];
  end

  always_comb begin
    neg_t = new_t_r < old_t_r;
    dt_w  = neg_t ? old_t_r - new_t_r : new_t_r - old_t_r;
    neg_c = new_c_r < old_c_r;
    dc_w  = neg_c ? old_c_r - new_c_r : new_c_r - old_c_r;
    rem_sh = {rem_r, lo_r[bit_r[5:0]]};
    q_set  = rem_sh[64] || (rem_sh[63:0] >= den_r);
    lo_sum = p0_r + {p1_r[31:0], 32'd0};
    sum_ext = {1'b0, sum_r} + {1'b0, crate_r};
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    peak_nxt = peak_r;
    act_nxt = act_r; ch_in_nxt = ch_in_r; cnt_nxt = cnt_r; now_nxt = now_r; win_nxt = win_r;
    ch_nxt = ch_r; idx_nxt = idx_r; step_nxt = step_r;
    new_t_nxt = new_t_r; new_c_nxt = new_c_r; old_t_nxt = old_t_r; old_c_nxt = old_c_r;
    full_nxt = full_r;
    den_nxt = den_r; mag_nxt = mag_r; rem_nxt = rem_r; lo_nxt = lo_r; q_nxt = q_r;
    bit_nxt = bit_r; mph_nxt = mph_r; p0_nxt = p0_r; p1_nxt = p1_r; sat_nxt = sat_r;
    cv_nxt = cv_r; crate_nxt = crate_r; sum_nxt = sum_r;
    o_rate_nxt = o_rate_r; o_peak_nxt = o_peak_r; o_rv_nxt = o_rv_r; o_v_nxt = o_v_r;
    for (int c = 0; c < CHANNELS; c++) begin
      wptr_nxt[c] = wptr_r[c];
    end
    mem_we = 1'b0; cnt_we = 1'b0;
    mem_wa = {ch_in_r[CW-1:0], wptr_r[ch_in_r[CW-1:0]]};
    mem_wc = cnt_r; mem_wt = now_r;
    mem_ra = {ch_idx, idx_r};
    in_stall = 1'b1;

    if (o_v_r && !out_stall) begin
      o_v_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        // sweep the time memory to empty
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wt = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEP - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = o_v_r;
        if (in_valid && !o_v_r) begin
          act_nxt = in_action; ch_in_nxt = in_channel; cnt_nxt = in_count;
          now_nxt = in_timestamp; win_nxt = in_window_ms;
          sum_nxt = '0;
          if (in_action == ACT_ADD) begin
            state_nxt = S_ADD;
          end else if (in_action == ACT_ONE) begin
            ch_nxt = {1'b0, in_channel[CW-1:0]};
            if (32'(in_channel) >= 32'(CHANNELS)) begin
              cv_nxt = 1'b0; crate_nxt = '0;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_CHAN;
            end
          end else begin
            ch_nxt = '0;
            state_nxt = S_CHAN;
          end
        end
      end
      S_ADD: begin
        if (32'(ch_in_r) < 32'(CHANNELS)) begin
          mem_we = 1'b1; cnt_we = 1'b1;
          wptr_nxt[ch_in_r[CW-1:0]] = wptr_r[ch_in_r[CW-1:0]] + 1'b1;
        end
        o_rate_nxt = '0; o_rv_nxt = 1'b0; o_peak_nxt = peak_r; o_v_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CHAN: begin
        // start a walk from the newest sample of this channel
        idx_nxt = wptr_r[ch_idx] - 1'b1;
        step_nxt = (BW+1)'(1);
        new_t_nxt = '0; new_c_nxt = '0; old_t_nxt = '0; old_c_nxt = '0;
        full_nxt = 1'b0;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (rd_tim_r == 64'd0) begin
          state_nxt = S_EVAL;
        end else begin
          if (new_t_r == 64'd0) begin
            new_t_nxt = rd_tim_r; new_c_nxt = rd_cnt_r;
          end
          if ((now_r - rd_tim_r) > {32'd0, cur_win}) begin
            full_nxt = 1'b1;
            state_nxt = S_EVAL;
          end else begin
            old_t_nxt = rd_tim_r; old_c_nxt = rd_cnt_r;
            if (step_r == (BW+1)'(BUCKETS - 1)) begin
              state_nxt = S_EVAL;
            end else begin
              step_nxt = step_r + 1'b1;
              idx_nxt = idx_r - 1'b1;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_EVAL: begin
        cv_nxt = 1'b0; crate_nxt = '0;
        if (!full_r || old_t_r == 64'd0 || new_t_r == 64'd0 || new_t_r == old_t_r ||
            (dc_w != 64'd0 && neg_t != neg_c)) begin
          state_nxt = S_ACC;
        end else begin
          den_nxt = dt_w; mag_nxt = dc_w; mph_nxt = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // two 32x32 products, then assemble the 128-bit numerator
        mph_nxt = mph_r + 1'b1;
        case (mph_r)
          2'd0: p0_nxt = mag_r[31:0] * SCALE_K;
          2'd1: p1_nxt = mag_r[63:32] * SCALE_K;
          default: begin
            lo_nxt = lo_sum;
            rem_nxt = {32'd0, p1_r[63:32]} + {63'd0, (lo_sum < p0_r)};
            q_nxt = '0;
            bit_nxt = 7'd63;
            state_nxt = S_DIV;
          end
        endcase
        if (mph_r == 2'd3) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (bit_r == 7'd63 && rem_r >= den_r && q_r == 64'd0 && !sat_r) begin
          sat_nxt = 1'b1;
        end
        if (sat_r || (bit_r == 7'd63 && rem_r >= den_r && q_r == 64'd0)) begin
          sat_nxt = 1'b0;
          crate_nxt = RATE_MAX; cv_nxt = 1'b1;
          state_nxt = S_ACC;
        end else begin
          rem_nxt = q_set ? rem_sh[63:0] - den_r : rem_sh[63:0];
          q_nxt = {q_r[62:0], q_set};
          if (bit_r == 7'd0) begin
            cv_nxt = 1'b1;
            crate_nxt = (q_r[62:47] != 16'd0) ? RATE_MAX : {q_r[46:0], q_set};
            state_nxt = S_ACC;
          end else begin
            bit_nxt = bit_r - 1'b1;
          end
        end
      end
      S_ACC: begin
        if (act_r == ACT_ONE) begin
          state_nxt = S_OUT;
        end else begin
          if (cv_r) begin
            sum_nxt = sum_ext[48] ? RATE_MAX : sum_ext[47:0];
          end
          if (ch_r == CCW'(CHANNELS - 1)) begin
            state_nxt = S_OUT;
          end else begin
            ch_nxt = ch_r + 1'b1;
            state_nxt = S_CHAN;
          end
        end
      end
      S_OUT: begin
        o_v_nxt = 1'b1;
        if (act_r == ACT_ONE) begin
          o_rate_nxt = crate_r; o_rv_nxt = cv_r; o_peak_nxt = peak_r;
        end else begin
          o_rate_nxt = sum_r; o_rv_nxt = 1'b1;
          if (act_r == ACT_PEAK && sum_r > peak_r) begin
            peak_nxt = sum_r;
            o_peak_nxt = sum_r;
          end else begin
            o_peak_nxt = peak_r;
          end
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      peak_r <= '0;
      pwin_r <= PEAK_WIN_RST;
      o_v_r <= 1'b0;
      sat_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wptr_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      peak_r <= peak_nxt;
      o_v_r <= o_v_nxt;
      sat_r <= sat_nxt;
      if (cfg_we) begin
        pwin_r <= cfg_wdata;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        wptr_r[c] <= wptr_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt; ch_in_r <= ch_in_nxt; cnt_r <= cnt_nxt; now_r <= now_nxt;
    win_r <= win_nxt; ch_r <= ch_nxt; idx_r <= idx_nxt; step_r <= step_nxt;
    new_t_r <= new_t_nxt; new_c_r <= new_c_nxt; old_t_r <= old_t_nxt; old_c_r <= old_c_nxt;
    full_r <= full_nxt; den_r <= den_nxt; mag_r <= mag_nxt; rem_r <= rem_nxt;
    lo_r <= lo_nxt; q_r <= q_nxt; bit_r <= bit_nxt; mph_r <= mph_nxt;
    p0_r <= p0_nxt; p1_r <= p1_nxt; cv_r <= cv_nxt; crate_r <= crate_nxt; sum_r <= sum_nxt;
    o_rate_r <= o_rate_nxt; o_peak_r <= o_peak_nxt; o_rv_r <= o_rv_nxt;
  end

  assign out_valid = o_v_r;
  assign out_rate = o_rate_r;
  assign out_rate_valid = o_rv_r;
  assign out_peak = o_peak_r;

`ifndef ASSERT_OFF
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("beat taken while busy");
  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (peak_r >= $past(peak_r))) else $error("peak fell");
  a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |=> (o_v_r && !o_rv_r && o_rate_r == 48'd0))
    else $error("add beat malformed");
  a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !o_v_r) else $error("result during clear");
`endif
endmodule

// File: dv/windowed_event_rate_meter_checker.sv
module windowed_event_rate_meter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_channel,
  input  logic [63:0] in_count,
  input  logic [63:0] in_timestamp,
  input  logic [31:0] in_window_ms,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [47:0] out_rate,
  input  logic        out_rate_valid,
  input  logic [47:0] out_peak,
  output int          mismatches,
  output int          outstanding
);
  import wrm_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam int NB  = BUCKETS_DEF;

  typedef struct {
    logic [47:0] rate;
    logic        rate_valid;
    logic [47:0] peak;
  } meter_result_t;

  logic [63:0]   ring_count [NCH][NB];
  logic [63:0]   ring_time  [NCH][NB];
  logic [7:0]    head [NCH];
  logic [47:0]   peak_hold;
  logic [31:0]   peak_win;
  meter_result_t rate_due_q [$];

  // floor(dc * 65536000 / dt), saturated to 48 bits
  function automatic logic [47:0] scale_rate(logic [63:0] dc, logic [63:0] dt);
    logic [127:0] q;
    q = ({64'd0, dc} * 128'(SCALE_K)) / {64'd0, dt};
    return (q > 128'(RATE_MAX)) ? RATE_MAX : q[47:0];
  endfunction

  function automatic logic ring_rate(int ch, logic [63:0] now, logic [31:0] win,
                                     output logic [47:0] rate);
    logic [63:0] old_t, old_c, new_t, new_c, t, dt, dc;
    logic        full, neg_t, neg_c;
    logic [7:0]  idx;
    rate = '0;
    full = 1'b0;
    old_t = '0; old_c = '0; new_t = '0; new_c = '0;
    for (int i = 1; i < NB; i++) begin
      idx = head[ch] - 8'(i);
      t = ring_time[ch][idx];
      if (t == 0) break;
      if (new_t == 0) begin
        new_t = t;
        new_c = ring_count[ch][idx];
      end
      if (now - t > {32'd0, win}) begin
        full = 1'b1;
        break;
      end
      old_t = t;
      old_c = ring_count[ch][idx];
    end
    if (!full || old_t == 0 || new_t == 0 || new_t == old_t) return 1'b0;
    neg_t = new_t < old_t;
    dt = neg_t ? old_t - new_t : new_t - old_t;
    neg_c = new_c < old_c;
    dc = neg_c ? old_c - new_c : new_c - old_c;
    if (dc != 0 && neg_t != neg_c) return 1'b0;
    rate = scale_rate(dc, dt);
    return 1'b1;
  endfunction

  function automatic logic [47:0] summed_rate(logic [63:0] now, logic [31:0] win);
    logic [48:0] sum;
    logic [47:0] r;
    sum = '0;
    for (int c = 0; c < NCH; c++) begin
      if (ring_rate(c, now, win, r)) begin
        sum = sum + r;
        if (sum > 49'(RATE_MAX)) sum = 49'(RATE_MAX);
      end
    end
    return sum[47:0];
  endfunction

  always @(posedge clk) begin : track
    meter_result_t want, got_exp;
    logic [47:0]   r;
    if (!rst_n) begin
      foreach (ring_time[c, b]) begin
        ring_time[c][b]  = '0;
        ring_count[c][b] = '0;
      end
      foreach (head[c]) head[c] = '0;
      peak_hold = '0;
      peak_win = PEAK_WIN_RST;
      rate_due_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) peak_win = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (rate_due_q.size() == 0) begin
          $error("result beat with nothing expected: rate %0h peak %0h", out_rate, out_peak);
          mismatches++;
        end else begin
          got_exp = rate_due_q.pop_front();
          if (out_rate !== got_exp.rate) begin
            $error("rate: expected %0h, got %0h", got_exp.rate, out_rate);
            mismatches++;
          end
          if (out_rate_valid !== got_exp.rate_valid) begin
            $error("rate_valid: expected %0b, got %0b", got_exp.rate_valid, out_rate_valid);
            mismatches++;
          end
          if (out_peak !== got_exp.peak) begin
            $error("peak: expected %0h, got %0h", got_exp.peak, out_peak);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want.rate = '0;
        want.rate_valid = 1'b0;
        case (in_action)
          ACT_ADD: begin
            ring_count[in_channel][head[in_channel]] = in_count;
            ring_time[in_channel][head[in_channel]]  = in_timestamp;
            head[in_channel] = head[in_channel] + 8'd1;
          end
          ACT_ONE: begin
            want.rate_valid = ring_rate(in_channel, in_timestamp, in_window_ms, r);
            want.rate = r;
          end
          ACT_ALL: begin
            want.rate = summed_rate(in_timestamp, in_window_ms);
            want.rate_valid = 1'b1;
          end
          default: begin
            want.rate = summed_rate(in_timestamp, peak_win);
            want.rate_valid = 1'b1;
            if (want.rate > peak_hold) peak_hold = want.rate;
          end
        endcase
        want.peak = peak_hold;
        rate_due_q.push_back(want);
      end
    end
    outstanding = rate_due_q.size();
  end
endmodule

// File: dv/windowed_event_rate_meter_tb.sv
module windowed_event_rate_meter_tb;
  import wrm_pkg::*;

  // Bound on the whole run; the slowest correct run sits far below this.
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [3:0]  in_channel;
  logic [63:0] in_count;
  logic [63:0] in_timestamp;
  logic [31:0] in_window_ms;
  logic        out_valid;
  logic        out_stall;
  logic [47:0] out_rate;
  logic        out_rate_valid;
  logic [47:0] out_peak;

  int mismatches;
  int outstanding;
  int cycles = 0;

  // calm: no gaps on either side; long_hold: ask the receiver for one long hold-off
  bit calm = 1'b0;
  bit long_hold = 1'b0;

  // Per-channel running time and count, so most adds form well-ordered sequences
  logic [63:0] chan_now [16];
  logic [63:0] chan_tally [16];

  windowed_event_rate_meter dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_channel(in_channel), .in_count(in_count),
    .in_timestamp(in_timestamp), .in_window_ms(in_window_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rate(out_rate), .out_rate_valid(out_rate_valid), .out_peak(out_peak)
  );

  windowed_event_rate_meter_checker rate_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_channel(in_channel), .in_count(in_count),
    .in_timestamp(in_timestamp), .in_window_ms(in_window_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rate(out_rate), .out_rate_valid(out_rate_valid), .out_peak(out_peak),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("windowed_event_rate_meter_tb failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all in calm stretches
  function automatic int pause_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request so the block
  // fills up and holds its input stalled while the sender keeps offering.
  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else begin
        n = pause_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Offer one beat after a random gap and hold it until accepted. Return at the
  // accepting edge with valid still high; the next call or settle() drops it.
  task automatic send_beat(logic [1:0] act, logic [3:0] ch, logic [63:0] cnt,
                           logic [63:0] ts, logic [31:0] win);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_channel   <= ch;
    in_count     <= cnt;
    in_timestamp <= ts;
    in_window_ms <= win;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait for every expected result to come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_peak_window(logic [31:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-ordered add on one channel: advance its time, and its count but for a rare fall.
  task automatic add_next(logic [3:0] ch);
    chan_now[ch] = chan_now[ch] + $urandom_range(1, 300);
    if ($urandom_range(0, 19) == 0)
      chan_tally[ch] = chan_tally[ch] - $urandom_range(0, 5000);
    else
      chan_tally[ch] = chan_tally[ch] + $urandom_range(0, 20000);
    send_beat(ACT_ADD, ch, chan_tally[ch], chan_now[ch], 32'd0);
  endtask

  task automatic run_phase(int n);
    int r;
    logic [3:0] ch;
    logic [31:0] win;
    for (int k = 0; k < n; k++) begin
      r  = $urandom_range(0, 99);
      ch = 4'($urandom_range(0, 15));
      win = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3000);
      if (r < 72) add_next(ch);
      else if (r < 80)
        // noise: any count, any time
        send_beat(ACT_ADD, ch, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      else if (r < 93) begin
        if ($urandom_range(0, 7) == 0)
          send_beat(ACT_ONE, ch, {$urandom, $urandom}, {$urandom, $urandom}, win);
        else
          send_beat(ACT_ONE, ch, {$urandom, $urandom},
                    chan_now[ch] + $urandom_range(0, 500), win);
      end else if (r < 97)
        send_beat(ACT_ALL, ch, {$urandom, $urandom}, chan_now[ch] + $urandom_range(0, 500), win);
      else
        send_beat(ACT_PEAK, ch, {$urandom, $urandom}, chan_now[ch], win);
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_action    <= ACT_ADD;
    in_channel   <= '0;
    in_count     <= '0;
    in_timestamp <= '0;
    in_window_ms <= '0;
    foreach (chan_now[c]) begin
      chan_now[c]   = 64'd1000 + c;
      chan_tally[c] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty ring: no samples at all, so the rate is undefined
    send_beat(ACT_ONE, 4'd0, '0, 64'd500, 32'd100);
    // Plain rate: 1000 events over 1000 ms with one sample outside the window
    send_beat(ACT_ADD, 4'd1, 64'd100, 64'd1000, '0);
    send_beat(ACT_ADD, 4'd1, 64'd200, 64'd2000, '0);
    send_beat(ACT_ADD, 4'd1, 64'd1200, 64'd3000, '0);
    send_beat(ACT_ONE, 4'd1, '0, 64'd3000, 32'd1500);
    // Window covers every sample: nothing older, undefined
    send_beat(ACT_ONE, 4'd1, '0, 64'd3000, 32'd5000);
    // Huge count step over 1 ms: saturate
    send_beat(ACT_ADD, 4'd2, 64'd0, 64'd5, '0);
    send_beat(ACT_ADD, 4'd2, 64'd0, 64'd10, '0);
    send_beat(ACT_ADD, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'd11, '0);
    send_beat(ACT_ONE, 4'd2, '0, 64'd11, 32'd1);
    // Both differences negative: magnitudes used, still valid
    send_beat(ACT_ADD, 4'd3, 64'd50, 64'd100, '0);
    send_beat(ACT_ADD, 4'd3, 64'd500, 64'd300, '0);
    send_beat(ACT_ADD, 4'd3, 64'd100, 64'd200, '0);
    send_beat(ACT_ONE, 4'd3, '0, 64'd300, 32'd150);
    // Count falls while time rises: opposite signs, undefined
    send_beat(ACT_ADD, 4'd4, 64'd10, 64'd100, '0);
    send_beat(ACT_ADD, 4'd4, 64'd5, 64'd200, '0);
    send_beat(ACT_ADD, 4'd4, 64'd1, 64'd300, '0);
    send_beat(ACT_ONE, 4'd4, '0, 64'd300, 32'd150);
    // Equal newest and oldest in-window times: undefined
    send_beat(ACT_ADD, 4'd6, 64'd1, 64'd50, '0);
    send_beat(ACT_ADD, 4'd6, 64'd3, 64'd60, '0);
    send_beat(ACT_ONE, 4'd6, '0, 64'd60, 32'd5);
    // Zero time marks an empty slot; top channel, all-ones time and window
    send_beat(ACT_ADD, 4'd7, 64'd9, 64'd0, '0);
    send_beat(ACT_ADD, 4'd15, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(ACT_ALL, 4'd0, '0, 64'd3000, 32'hFFFF_FFFF);
    send_beat(ACT_PEAK, 4'd0, '0, 64'd3000, '0);

    // Peak window at both extremes
    write_peak_window(32'd1);
    send_beat(ACT_PEAK, 4'd0, '0, 64'd11, '0);
    write_peak_window(32'hFFFF_FFFF);
    send_beat(ACT_PEAK, 4'd0, '0, 64'd3000, '0);

    // Wrap one ring past its depth, then walk it full length and short
    for (int k = 0; k < 270; k++) add_next(4'd9);
    send_beat(ACT_ONE, 4'd9, '0, chan_now[9], 32'hFFFF_FFFF);
    send_beat(ACT_ONE, 4'd9, '0, chan_now[9], 32'd1000);
    send_beat(ACT_ALL, 4'd9, '0, chan_now[9], 32'd2000);

    write_peak_window(32'd500);
    run_phase(220);
    write_peak_window(32'd250000);
    calm = 1'b1;
    run_phase(210);
    calm = 1'b0;
    long_hold = 1'b1;
    run_phase(210);
    write_peak_window(PEAK_WIN_RST);
    run_phase(200);

    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("windowed_event_rate_meter_tb passed");
    else
      $display("windowed_event_rate_meter_tb failed");
    $finish;
  end
endmodule

// File: windowed_event_rate_meter.f
hdl/wrm_pkg.sv
hdl/windowed_event_rate_meter.sv
dv/windowed_event_rate_meter_checker.sv
dv/windowed_event_rate_meter_tb.sv
